// ===== design/sdh_pkg.sv =====
// ----------------------------------------------------------------------------
// sdh_pkg
// Shared widths, codes, reset values and control bundles of the stall-detect
// homing sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sdh_pkg;

    localparam int VEL_W      = 24;
    localparam int POS_W      = 32;
    localparam int EPS_W      = 16;
    localparam int LIM_W      = 12;
    localparam int FRAME_W    = 16;
    localparam int AXES_W     = 2;
    localparam int MASK_W     = 3;
    localparam int STAT_W     = 3;
    localparam int CMD_W      = 2;
    localparam int MAX_AXES   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int RAMP_LENGTH_DEF = 100;
    localparam int NUM_AXES_DEF    = 3;

    localparam logic [LIM_W-1:0] STILL_MAX = {LIM_W{1'b1}};

    // register reset values
    localparam logic [VEL_W-1:0]   RETRACT_RST = VEL_W'(-24'sd10000);
    localparam logic [EPS_W-1:0]   EPSILON_RST = EPS_W'(50);
    localparam logic [LIM_W-1:0]   LIMIT_RST   = LIM_W'(50);
    localparam logic [FRAME_W-1:0] MAX_SEEK_RST = FRAME_W'(5000);
    localparam logic [AXES_W-1:0]  AXES_RST    = AXES_W'(3);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RETRACT_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_EPSILON   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEEK_FRAMES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_AXES     = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_ABORT = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        PH_IDLE    = 3'd0,
        PH_RAMP    = 3'd1,
        PH_SEEK    = 3'd2,
        PH_DONE    = 3'd3,
        PH_TIMEOUT = 3'd4,
        PH_ABORT   = 3'd5
    } t_phase;

    typedef struct packed {
        logic clear;
        logic step;
    } t_ramp_ctl;

    typedef struct packed {
        logic clear;
        logic load;
        logic check;
    } t_axis_ctl;

endpackage

`default_nettype wire

// ===== design/sdh_in_if.sv =====
// ----------------------------------------------------------------------------
// sdh_in_if
// Command channel: command code and three measured axis positions.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdh_in_if;
    logic                             valid;
    logic                             ready;
    logic [sdh_pkg::CMD_W-1:0]        command;
    logic signed [sdh_pkg::POS_W-1:0] position_a;
    logic signed [sdh_pkg::POS_W-1:0] position_b;
    logic signed [sdh_pkg::POS_W-1:0] position_c;

    modport source (output valid, command, position_a, position_b, position_c,
                    input ready);
    modport sink   (input valid, command, position_a, position_b, position_c,
                    output ready);
endinterface

`default_nettype wire

// ===== design/sdh_out_if.sv =====
// ----------------------------------------------------------------------------
// sdh_out_if
// Result channel: per-axis velocity commands, stopped mask and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdh_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [sdh_pkg::VEL_W-1:0] velocity_a;
    logic signed [sdh_pkg::VEL_W-1:0] velocity_b;
    logic signed [sdh_pkg::VEL_W-1:0] velocity_c;
    logic [sdh_pkg::MASK_W-1:0]       stopped_mask;
    logic [sdh_pkg::STAT_W-1:0]       status;

    modport source (output valid, velocity_a, velocity_b, velocity_c, stopped_mask,
                    status, input ready);
    modport sink   (input valid, velocity_a, velocity_b, velocity_c, stopped_mask,
                    status, output ready);
endinterface

`default_nettype wire

// ===== design/sdh_ramp.sv =====
// ----------------------------------------------------------------------------
// sdh_ramp
// Ramp velocity generator: retract_speed * i / RAMP_LENGTH truncated toward
// zero, via a tracked reciprocal coefficient ceil(i * 2^SH / RAMP_LENGTH).
// ----------------------------------------------------------------------------
`default_nettype none

module sdh_ramp #(
    parameter int RAMP_LENGTH = sdh_pkg::RAMP_LENGTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire sdh_pkg::t_ramp_ctl             i_ctl,
    input  wire logic [sdh_pkg::VEL_W-1:0]      i_retract_speed,
    output logic      [sdh_pkg::VEL_W-1:0]      o_ramp_vel
);

    // shift large enough that |speed| * RAMP_LENGTH < 2^SH keeps the floor exact
    localparam int SCALE_SH  = sdh_pkg::VEL_W - 1 + $clog2(RAMP_LENGTH);
    localparam int COEF_W    = SCALE_SH + 1;
    localparam int RAMP_BITS = (RAMP_LENGTH > 1) ? $clog2(RAMP_LENGTH) : 1;
    localparam int PROD_W    = sdh_pkg::VEL_W + COEF_W;
    localparam logic [COEF_W-1:0] STEP_Q =
        COEF_W'((64'd1 << SCALE_SH) / RAMP_LENGTH);
    localparam logic [RAMP_BITS-1:0] STEP_R =
        RAMP_BITS'((64'd1 << SCALE_SH) % RAMP_LENGTH);
    localparam logic [RAMP_BITS:0] LEN_EXT = (RAMP_BITS+1)'(RAMP_LENGTH);

    logic [COEF_W-1:0]    r_base, n_base;
    logic [RAMP_BITS-1:0] r_rem, n_rem;
    logic [RAMP_BITS:0]   w_rem_sum;
    logic                 w_wrap;
    logic [COEF_W-1:0]    w_coef;
    logic [sdh_pkg::VEL_W-1:0] w_mag, w_quot;
    logic [PROD_W-1:0]    w_prod;

    always_comb begin
        w_rem_sum = {1'b0, r_rem} + {1'b0, STEP_R};
        w_wrap    = (w_rem_sum >= LEN_EXT);
        priority if (i_ctl.clear) begin
            n_base = '0;
            n_rem  = '0;
        end else if (i_ctl.step) begin
            n_base = r_base + STEP_Q + COEF_W'(w_wrap);
            n_rem  = w_wrap ? RAMP_BITS'(w_rem_sum - LEN_EXT) : RAMP_BITS'(w_rem_sum);
        end else begin
            n_base = r_base;
            n_rem  = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_rem  <= '0;
        end else begin
            r_base <= n_base;
            r_rem  <= n_rem;
        end
    end

    // ceiling of the scaled fraction i / RAMP_LENGTH
    assign w_coef = r_base + COEF_W'(r_rem != '0);

    always_comb begin
        w_mag  = i_retract_speed[sdh_pkg::VEL_W-1] ? (~i_retract_speed + 1'b1)
                                                   : i_retract_speed;
        w_prod = PROD_W'(w_mag) * PROD_W'(w_coef);
        w_quot = w_prod[SCALE_SH +: sdh_pkg::VEL_W];
        o_ramp_vel = i_retract_speed[sdh_pkg::VEL_W-1] ? (~w_quot + 1'b1) : w_quot;
    end

endmodule

`default_nettype wire

// ===== design/sdh_axis.sv =====
// ----------------------------------------------------------------------------
// sdh_axis
// Per-axis stall detector: movement window, still-frame counter and
// stopped flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sdh_axis (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sdh_pkg::t_axis_ctl          i_ctl,
    input  wire logic [sdh_pkg::POS_W-1:0]   i_position,
    input  wire logic [sdh_pkg::EPS_W-1:0]   i_epsilon,
    input  wire logic [sdh_pkg::LIM_W-1:0]   i_limit,
    output logic                             o_stopped,
    output logic                             o_stopped_nxt
);

    localparam int DIFF_W = sdh_pkg::POS_W + 1;

    logic [sdh_pkg::POS_W-1:0] r_window, n_window;
    logic [sdh_pkg::LIM_W-1:0] r_still, n_still;
    logic                      r_stopped, n_stopped;

    logic [sdh_pkg::POS_W-1:0] w_win_eff;
    logic [sdh_pkg::LIM_W-1:0] w_still_eff, w_still_inc;
    logic [DIFF_W-1:0]         w_diff, w_moved;
    logic                      w_moving;

    always_comb begin
        // entering seek loads the window from this beat's position
        w_win_eff   = i_ctl.load ? i_position : r_window;
        w_still_eff = i_ctl.load ? '0 : r_still;
        w_diff      = {i_position[sdh_pkg::POS_W-1], i_position}
                    - {w_win_eff[sdh_pkg::POS_W-1], w_win_eff};
        w_moved     = w_diff[DIFF_W-1] ? (~w_diff + 1'b1) : w_diff;
        w_moving    = (w_moved > DIFF_W'(i_epsilon));
        w_still_inc = (w_still_eff == sdh_pkg::STILL_MAX) ? w_still_eff
                                                          : w_still_eff + 1'b1;

        n_window  = w_win_eff;
        n_still   = w_still_eff;
        n_stopped = r_stopped;
        priority if (i_ctl.clear) begin
            n_still   = '0;
            n_stopped = 1'b0;
        end else if (i_ctl.check && !r_stopped) begin
            if (w_moving) begin
                n_window = i_position;
                n_still  = '0;
            end else begin
                n_still = w_still_inc;
                if (w_still_inc >= i_limit) begin
                    n_stopped = 1'b1;
                end
            end
        end else begin
            n_stopped = r_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        r_window <= n_window;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_still   <= '0;
            r_stopped <= 1'b0;
        end else begin
            r_still   <= n_still;
            r_stopped <= n_stopped;
        end
    end

    assign o_stopped     = r_stopped;
    assign o_stopped_nxt = n_stopped;

endmodule

`default_nettype wire

// ===== design/stall_detect_homing_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// stall_detect_homing_sequencer_unit
// Homes up to three axes by driving them into their mechanical stops.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one beat per control frame: start, frame tick with the
//   three measured positions, or abort. o_res returns exactly one beat per
//   command beat: three velocity commands, the stopped mask and the status.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_wdata, one per
//   cycle, by the user only while no command is in flight (not enforced).
// Pipeline and throughput:
//   A command beat is held in the input register, is evaluated by the ramp
//   multiplier and the per-axis window compares, and is registered into the
//   result register that drives o_res. One beat per cycle is taken while
//   o_res.ready holds; the ramp uses one 24 x 31 bit multiply.
// Stalls:
//   The result register holds its beat until o_res.ready; the input register
//   keeps accepting as long as the result can move, so a stalled receiver
//   backs up into i_cmd.ready after one buffered beat.
// Reset:
//   Synchronous, active low. Phase returns to idle, counts and stopped flags
//   clear, registers take their default values; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module stall_detect_homing_sequencer_unit #(
    parameter int RAMP_LENGTH = sdh_pkg::RAMP_LENGTH_DEF,
    parameter int NUM_AXES    = sdh_pkg::NUM_AXES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    sdh_in_if.sink                                 i_cmd,
    sdh_out_if.source                              o_res,
    input  wire logic                              i_cfg_we,
    input  wire logic [sdh_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [sdh_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int NA = sdh_pkg::MAX_AXES;

    // configuration
    logic [sdh_pkg::VEL_W-1:0]   r_retract_speed;
    logic [sdh_pkg::EPS_W-1:0]   r_stall_epsilon;
    logic [sdh_pkg::LIM_W-1:0]   r_stall_limit;
    logic [sdh_pkg::FRAME_W-1:0] r_max_seek;
    logic [sdh_pkg::AXES_W-1:0]  r_active_axes;

    // input register
    logic                        r_in_vld;
    logic [sdh_pkg::CMD_W-1:0]   r_in_cmd;
    logic [sdh_pkg::POS_W-1:0]   r_in_pos [NA];

    // result register
    logic                        r_out_vld;
    logic [sdh_pkg::VEL_W-1:0]   r_out_vel [NA];
    logic [sdh_pkg::MASK_W-1:0]  r_out_mask;
    logic [sdh_pkg::STAT_W-1:0]  r_out_status;

    // run state
    sdh_pkg::t_phase             r_phase, n_phase;
    logic [sdh_pkg::FRAME_W-1:0] r_frame, n_frame;

    logic                        w_adv, w_in_beat;
    logic                        w_start, w_abort, w_tick;
    logic                        w_ramp_tick, w_seek_tick, w_seek_entry;
    logic                        w_all_stopped, w_timeout, w_timeout_fire;
    logic [sdh_pkg::FRAME_W-1:0] w_seek_base, w_seek_inc;
    logic [NA-1:0]               w_active, w_stopped, w_stop_nxt;
    logic [sdh_pkg::VEL_W-1:0]   w_ramp_vel;
    logic [sdh_pkg::VEL_W-1:0]   w_vel [NA];
    sdh_pkg::t_ramp_ctl          w_ramp_ctl;
    sdh_pkg::t_axis_ctl          w_axis_ctl [NA];

    // ------------------------------------------------------------------
    // handshake
    assign w_adv       = r_in_vld & (~r_out_vld | o_res.ready);
    assign i_cmd.ready = ~r_in_vld | w_adv;
    assign w_in_beat   = i_cmd.valid & i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= w_in_beat | (r_in_vld & ~w_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_in_cmd    <= i_cmd.command;
            r_in_pos[0] <= i_cmd.position_a;
            r_in_pos[1] <= i_cmd.position_b;
            r_in_pos[2] <= i_cmd.position_c;
        end
    end

    // ------------------------------------------------------------------
    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retract_speed <= sdh_pkg::RETRACT_RST;
            r_stall_epsilon <= sdh_pkg::EPSILON_RST;
            r_stall_limit   <= sdh_pkg::LIMIT_RST;
            r_max_seek      <= sdh_pkg::MAX_SEEK_RST;
            r_active_axes   <= sdh_pkg::AXES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sdh_pkg::CFG_RETRACT_SPEED: begin
                    r_retract_speed <= i_cfg_wdata[sdh_pkg::VEL_W-1:0];
                end
                sdh_pkg::CFG_STALL_EPSILON: begin
                    r_stall_epsilon <= i_cfg_wdata[sdh_pkg::EPS_W-1:0];
                end
                sdh_pkg::CFG_STALL_LIMIT: begin
                    r_stall_limit <= i_cfg_wdata[sdh_pkg::LIM_W-1:0];
                end
                sdh_pkg::CFG_MAX_SEEK_FRAMES: begin
                    r_max_seek <= i_cfg_wdata[sdh_pkg::FRAME_W-1:0];
                end
                sdh_pkg::CFG_ACTIVE_AXES: begin
                    r_active_axes <= i_cfg_wdata[sdh_pkg::AXES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // command decode
    assign w_start = w_adv & (r_in_cmd == sdh_pkg::CMD_START);
    assign w_abort = w_adv & (r_in_cmd == sdh_pkg::CMD_ABORT);
    assign w_tick  = w_adv & (r_in_cmd == sdh_pkg::CMD_TICK);

    assign w_ramp_tick  = w_tick & (r_phase == sdh_pkg::PH_RAMP)
                        & (r_frame < sdh_pkg::FRAME_W'(RAMP_LENGTH));
    assign w_seek_entry = w_tick & (r_phase == sdh_pkg::PH_RAMP)
                        & (r_frame >= sdh_pkg::FRAME_W'(RAMP_LENGTH));
    assign w_seek_tick  = w_seek_entry | (w_tick & (r_phase == sdh_pkg::PH_SEEK));

    // ------------------------------------------------------------------
    // ramp generator and axes
    assign w_ramp_ctl.clear = w_start;
    assign w_ramp_ctl.step  = w_ramp_tick;

    sdh_ramp #(
        .RAMP_LENGTH (RAMP_LENGTH)
    ) u_ramp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ramp_ctl),
        .i_retract_speed (r_retract_speed),
        .o_ramp_vel      (w_ramp_vel)
    );

    for (genvar k = 0; k < NA; k++) begin : g_axis
        if (k < NUM_AXES) begin : g_used
            assign w_active[k]         = ({1'b0, r_active_axes} > 3'(k));
            assign w_axis_ctl[k].clear = w_start;
            assign w_axis_ctl[k].load  = w_seek_entry;
            assign w_axis_ctl[k].check = w_seek_tick & w_active[k];

            sdh_axis u_axis (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_axis_ctl[k]),
                .i_position    (r_in_pos[k]),
                .i_epsilon     (r_stall_epsilon),
                .i_limit       (r_stall_limit),
                .o_stopped     (w_stopped[k]),
                .o_stopped_nxt (w_stop_nxt[k])
            );
        end else begin : g_unused
            assign w_active[k]   = 1'b0;
            assign w_axis_ctl[k] = '0;
            assign w_stopped[k]  = 1'b0;
            assign w_stop_nxt[k] = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // seek bookkeeping
    always_comb begin
        w_all_stopped  = &(w_stop_nxt | ~w_active);
        w_seek_base    = w_seek_entry ? '0 : r_frame;
        w_seek_inc     = w_seek_base + 1'b1;
        w_timeout      = (w_seek_inc >= r_max_seek) || (w_seek_inc == '0);
        w_timeout_fire = w_seek_tick & ~w_all_stopped & w_timeout;
    end

    // next phase
    always_comb begin
        priority if (w_start) begin
            n_phase = sdh_pkg::PH_RAMP;
        end else if (w_abort) begin
            n_phase = sdh_pkg::PH_ABORT;
        end else if (w_seek_tick) begin
            if (w_all_stopped) begin
                n_phase = sdh_pkg::PH_DONE;
            end else if (w_timeout) begin
                n_phase = sdh_pkg::PH_TIMEOUT;
            end else begin
                n_phase = sdh_pkg::PH_SEEK;
            end
        end else begin
            n_phase = r_phase;
        end
    end

    // frame counter and velocity outputs
    always_comb begin
        priority if (w_start) begin
            n_frame = '0;
        end else if (w_ramp_tick) begin
            n_frame = r_frame + 1'b1;
        end else if (w_seek_tick) begin
            n_frame = w_all_stopped ? w_seek_base : w_seek_inc;
        end else begin
            n_frame = r_frame;
        end

        for (int k = 0; k < NA; k++) begin
            w_vel[k] = '0;
            if (w_ramp_tick && w_active[k]) begin
                w_vel[k] = w_ramp_vel;
            end else if (w_seek_tick && w_active[k] && !w_stop_nxt[k]
                         && !w_timeout_fire) begin
                w_vel[k] = r_retract_speed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sdh_pkg::PH_IDLE;
            r_frame <= '0;
        end else begin
            r_phase <= n_phase;
            r_frame <= n_frame;
        end
    end

    // ------------------------------------------------------------------
    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_adv | (r_out_vld & ~o_res.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_vel    <= w_vel;
            r_out_mask   <= w_stop_nxt;
            r_out_status <= sdh_pkg::STAT_W'(n_phase);
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.velocity_a   = r_out_vel[0];
    assign o_res.velocity_b   = r_out_vel[1];
    assign o_res.velocity_c   = r_out_vel[2];
    assign o_res.stopped_mask = r_out_mask;
    assign o_res.status       = r_out_status;

    // ------------------------------------------------------------------
    // assertions
    a_no_stop_before_seek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == sdh_pkg::PH_IDLE || r_phase == sdh_pkg::PH_RAMP) |-> (w_stopped == '0))
        else $error("axis marked stopped before seeking began");

    a_beat_reaches_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_vld)
        else $error("evaluated beat did not reach the result register");

    a_input_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_adv) |=> (r_in_vld && $stable(r_in_cmd)))
        else $error("blocked input beat was lost or changed");

    a_timeout_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_status == sdh_pkg::PH_TIMEOUT)
        |-> (r_out_vel[0] == '0 && r_out_vel[1] == '0 && r_out_vel[2] == '0))
        else $error("nonzero velocity reported with timeout status");

endmodule

`default_nettype wire
